FILE: sv/ntva_pkg.sv
// ---------------------------------------------------------------------------
// ntva_pkg
// Shared types, codes and note helpers for the note/track voice allocator.
// ---------------------------------------------------------------------------
package ntva_pkg;

  // Field widths fixed by the event format
  localparam int NOTE_W     = 7;
  localparam int TRK_W      = 5;
  localparam int INST_W     = 8;
  localparam int TC_W       = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  typedef logic [NOTE_W-1:0] note_t;

  // Note values with special meaning
  localparam note_t NOTE_FREE = 7'd120;  // free track / note-off event
  localparam note_t NOTE_TOP  = 7'd119;  // highest playable note

  // Four octaves of transposition
  localparam int          OCTAVE_SHIFT   = 4;
  localparam int          SEMITONES      = 12;
  localparam logic [7:0]  TRANSPOSE_STEP = 8'(OCTAVE_SHIFT * SEMITONES);

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_TRACK_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INSTRUMENT  = 1'b1;

  // Reset values of the configuration registers
  localparam logic [TC_W-1:0]   TRACK_COUNT_RST = 6'd16;
  localparam logic [INST_W-1:0] INSTRUMENT_RST  = 8'd0;

  // Event action codes
  localparam logic ACT_ON  = 1'b0;
  localparam logic ACT_OFF = 1'b1;

  // Optional +48 shift for playable notes, clamped to the top note;
  // notes of 120 and above pass unchanged
  function automatic note_t offset_note(input note_t n, input logic tr);
    logic [NOTE_W:0] sum;
    note_t           res;
    sum = {1'b0, n} + (tr ? TRANSPOSE_STEP : 8'd0);
    if (n >= NOTE_FREE) begin
      res = n;
    end else if (sum > {1'b0, NOTE_TOP}) begin
      res = NOTE_TOP;
    end else begin
      res = sum[NOTE_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: sv/note_track_voice_allocator.sv
// ---------------------------------------------------------------------------
// note_track_voice_allocator
// Round-robin assignment of note on/off events to tracks, with stealing.
// ---------------------------------------------------------------------------
// The note held by each track sits in a small RAM that is scanned one track
// per clock through its single read port, while a release scan is not held
// by a stalled output. An event of cnt active tracks (cnt = track_count
// clamped to 1..MAX_TRACK_COUNT) is accepted in S_IDLE and then runs, in
// order: a release scan of cnt tracks when its note is below 120, for a
// note-on a free-track search of up to cnt tracks, a second release scan
// when a held note is stolen, a step to record the note and a step to hand
// over the final result; a note-off of 120 or above ends at acceptance, and
// the output side may stall the event. Every result goes out through a
// one-deep hold stage and an output register, so "last" is known when the
// final result of an event is presented. No input is taken until all results
// of the previous event have been handed to the output register.
module note_track_voice_allocator #(
  parameter int MAX_TRACK_COUNT = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ntva_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ntva_pkg::CFG_DATA_W-1:0]       cfg_data,
  // event input
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  action,
  input  logic [ntva_pkg::NOTE_W-1:0]           note,
  input  logic                                  transpose,
  // result output
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [ntva_pkg::TRK_W-1:0]            track,
  output logic [ntva_pkg::NOTE_W-1:0]           out_note,
  output logic [ntva_pkg::INST_W-1:0]           out_instrument,
  output logic                                  last
);

  localparam int TW   = $clog2(MAX_TRACK_COUNT);
  localparam int CW   = $clog2(MAX_TRACK_COUNT + 1);
  localparam int CMPW = (CW > ntva_pkg::TC_W) ? CW : ntva_pkg::TC_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REL,
    S_SEARCH,
    S_WRITE,
    S_FINISH
  } state_t;

  // registers
  state_t                        state, state_next;
  logic [ntva_pkg::TC_W-1:0]     track_count;
  logic [ntva_pkg::INST_W-1:0]   instrument;
  logic [TW-1:0]                 last_track, last_track_next;
  ntva_pkg::note_t               cur_note, cur_note_next;
  logic                          cur_on, cur_on_next;
  ntva_pkg::note_t               rel_note, rel_note_next;
  logic                          rel_stolen, rel_stolen_next;
  logic [TW-1:0]                 chk_idx, chk_idx_next;
  logic [TW-1:0]                 k, k_next;
  ntva_pkg::note_t               start_note, start_note_next;
  logic [TW-1:0]                 pick, pick_next;
  logic                          pend_valid, pend_valid_next;
  logic [TW-1:0]                 pend_track, pend_track_next;
  ntva_pkg::note_t               pend_note, pend_note_next;
  logic                          out_vld, out_vld_next;
  logic [TW-1:0]                 out_trk, out_trk_next;
  ntva_pkg::note_t               out_nt, out_nt_next;
  logic [ntva_pkg::INST_W-1:0]   out_inst, out_inst_next;
  logic                          out_last, out_last_next;
  logic [MAX_TRACK_COUNT-1:0]    vld;
  logic                          rd_vld;
  logic                          fwd_hit;
  ntva_pkg::note_t               fwd_data;

  // combinational
  logic [CMPW-1:0]               tc_ext;
  logic [CW-1:0]                 cnt;
  logic [TW-1:0]                 last_idx;
  logic [CW:0]                   lt_inc;
  logic [TW-1:0]                 start_idx;
  ntva_pkg::note_t               ram_q;
  ntva_pkg::note_t               eff;
  ntva_pkg::note_t               in_nt;
  ntva_pkg::note_t               stolen;
  logic                          out_free;
  logic                          can_emit;
  logic                          emit;
  logic                          flush;
  logic [TW-1:0]                 emit_track;
  ntva_pkg::note_t               emit_note;
  logic                          we;
  logic [TW-1:0]                 waddr;
  ntva_pkg::note_t               wdata;
  logic [TW-1:0]                 raddr;
  logic                          found;
  logic [TW-1:0]                 nxt_idx;

  // note store
  ntva_ram #(
    .WIDTH (ntva_pkg::NOTE_W),
    .DEPTH (MAX_TRACK_COUNT)
  ) u_note_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // active track count, clamped to 1..MAX_TRACK_COUNT
  assign tc_ext   = CMPW'(track_count);
  assign cnt      = (track_count == '0) ? CW'(1) :
                    (tc_ext > CMPW'(MAX_TRACK_COUNT)) ? CW'(MAX_TRACK_COUNT) : CW'(tc_ext);
  assign last_idx = TW'(cnt - 1'b1);

  // search starts after the last used track, wrapping to track 0
  assign lt_inc    = (CW + 1)'(last_track) + 1'b1;
  assign start_idx = (lt_inc < (CW + 1)'(cnt)) ? TW'(lt_inc) : '0;

  // stored note of the entry under check; never-written entries are free
  assign eff = fwd_hit ? fwd_data : (rd_vld ? ram_q : ntva_pkg::NOTE_FREE);

  assign in_nt    = ntva_pkg::offset_note(note, transpose);
  assign stolen   = (k == '0) ? eff : start_note;
  assign found    = (eff == ntva_pkg::NOTE_FREE);
  assign nxt_idx  = (chk_idx == last_idx) ? '0 : TW'(chk_idx + 1'b1);

  // output side handshake
  assign out_free  = !out_vld || !out_stall;
  assign can_emit  = !pend_valid || out_free;
  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);

  // sequencer
  always_comb begin
    state_next      = state;
    last_track_next = last_track;
    cur_note_next   = cur_note;
    cur_on_next     = cur_on;
    rel_note_next   = rel_note;
    rel_stolen_next = rel_stolen;
    chk_idx_next    = chk_idx;
    k_next          = k;
    start_note_next = start_note;
    pick_next       = pick;
    raddr           = chk_idx;
    we              = 1'b0;
    waddr           = chk_idx;
    wdata           = ntva_pkg::NOTE_FREE;
    emit            = 1'b0;
    flush           = 1'b0;
    emit_track      = chk_idx;
    emit_note       = ntva_pkg::NOTE_FREE;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cur_note_next = in_nt;
          cur_on_next   = (action == ntva_pkg::ACT_ON);
          if (in_nt < ntva_pkg::NOTE_FREE) begin
            rel_note_next   = in_nt;
            rel_stolen_next = 1'b0;
            chk_idx_next    = '0;
            raddr           = '0;
            state_next      = S_REL;
          end else if (action == ntva_pkg::ACT_ON) begin
            chk_idx_next = start_idx;
            raddr        = start_idx;
            k_next       = '0;
            state_next   = S_SEARCH;
          end
        end
      end

      // clear every track holding rel_note, one off event each
      S_REL: begin
        if (!(eff == rel_note && !can_emit)) begin
          if (eff == rel_note) begin
            we        = 1'b1;
            waddr     = chk_idx;
            wdata     = ntva_pkg::NOTE_FREE;
            emit      = 1'b1;
            emit_note = ntva_pkg::NOTE_FREE;
          end
          if (chk_idx == last_idx) begin
            if (rel_stolen) begin
              state_next = S_WRITE;
            end else if (cur_on) begin
              chk_idx_next = start_idx;
              raddr        = start_idx;
              k_next       = '0;
              state_next   = S_SEARCH;
            end else begin
              state_next = S_FINISH;
            end
          end else begin
            chk_idx_next = TW'(chk_idx + 1'b1);
            raddr        = TW'(chk_idx + 1'b1);
          end
        end
      end

      // round-robin search for a free track, else steal the start track
      S_SEARCH: begin
        if (k == '0) begin
          start_note_next = eff;
        end
        if (found || k == last_idx) begin
          pick_next       = found ? chk_idx : start_idx;
          last_track_next = found ? chk_idx : start_idx;
          if (!found && stolen < ntva_pkg::NOTE_FREE) begin
            rel_note_next   = stolen;
            rel_stolen_next = 1'b1;
            chk_idx_next    = '0;
            raddr           = '0;
            state_next      = S_REL;
          end else begin
            state_next = S_WRITE;
          end
        end else begin
          chk_idx_next = nxt_idx;
          raddr        = nxt_idx;
          k_next       = TW'(k + 1'b1);
        end
      end

      // record the note and emit the on event
      S_WRITE: begin
        if (can_emit) begin
          we         = 1'b1;
          waddr      = pick;
          wdata      = cur_note;
          emit       = 1'b1;
          emit_track = pick;
          emit_note  = cur_note;
          state_next = S_FINISH;
        end
      end

      // hand the held result over as the final one
      S_FINISH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          flush      = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // hold stage and output register
  always_comb begin
    pend_valid_next = pend_valid;
    pend_track_next = pend_track;
    pend_note_next  = pend_note;
    out_vld_next    = out_vld && out_stall;
    out_trk_next    = out_trk;
    out_nt_next     = out_nt;
    out_inst_next   = out_inst;
    out_last_next   = out_last;

    if (emit) begin
      if (pend_valid) begin
        out_vld_next  = 1'b1;
        out_trk_next  = pend_track;
        out_nt_next   = pend_note;
        out_inst_next = instrument;
        out_last_next = 1'b0;
      end
      pend_valid_next = 1'b1;
      pend_track_next = emit_track;
      pend_note_next  = emit_note;
    end else if (flush) begin
      out_vld_next    = 1'b1;
      out_trk_next    = pend_track;
      out_nt_next     = pend_note;
      out_inst_next   = instrument;
      out_last_next   = 1'b1;
      pend_valid_next = 1'b0;
    end
  end

  // state, configuration and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      track_count <= ntva_pkg::TRACK_COUNT_RST;
      instrument  <= ntva_pkg::INSTRUMENT_RST;
      last_track  <= '0;
      pend_valid  <= 1'b0;
      out_vld     <= 1'b0;
      vld         <= '0;
      fwd_hit     <= 1'b0;
    end else begin
      state      <= state_next;
      last_track <= last_track_next;
      pend_valid <= pend_valid_next;
      out_vld    <= out_vld_next;
      fwd_hit    <= we && (waddr == raddr);
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ntva_pkg::CFG_TRACK_COUNT: track_count <= cfg_data[ntva_pkg::TC_W-1:0];
          ntva_pkg::CFG_INSTRUMENT:  instrument  <= cfg_data[ntva_pkg::INST_W-1:0];
        endcase
      end
    end
    cur_note   <= cur_note_next;
    cur_on     <= cur_on_next;
    rel_note   <= rel_note_next;
    rel_stolen <= rel_stolen_next;
    chk_idx    <= chk_idx_next;
    k          <= k_next;
    start_note <= start_note_next;
    pick       <= pick_next;
    pend_track <= pend_track_next;
    pend_note  <= pend_note_next;
    out_trk    <= out_trk_next;
    out_nt     <= out_nt_next;
    out_inst   <= out_inst_next;
    out_last   <= out_last_next;
    rd_vld     <= vld[raddr];
    fwd_data   <= wdata;
  end

  assign out_valid      = out_vld;
  assign track          = ntva_pkg::TRK_W'(out_trk);
  assign out_note       = out_nt;
  assign out_instrument = out_inst;
  assign last           = out_last;

  // a held result never outlives its event
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !pend_valid)
    else $error("result left in hold stage while idle");

  // the note store is only written while releasing or recording
  a_write_state: assert property (@(posedge clk) disable iff (rst)
    we |-> (state == S_REL || state == S_WRITE))
    else $error("note store written outside release or record");

  // search stays inside the active tracks
  a_search_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SEARCH |-> (k <= last_idx && chk_idx <= last_idx))
    else $error("search beyond active track count");

  // displacing a held result always fills the output register
  a_emit_moves: assert property (@(posedge clk) disable iff (rst)
    emit && pend_valid |=> out_valid)
    else $error("held result lost on emit");

endmodule

FILE: sv/ntva_ram.sv
// ---------------------------------------------------------------------------
// ntva_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ---------------------------------------------------------------------------
module ntva_ram #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = 32,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
